// ===== rtl/mh_pkg.sv =====
// Package with the shared constants, seed table and sequencer states of the MinHash engine.
`default_nettype none

package mh_pkg;

    // Number of seed slots in use, and the size of the seed table.
    localparam int NUM_SEEDS  = 16;
    localparam int SEED_SLOTS = 16;
    localparam int SEED_W     = (NUM_SEEDS > 1) ? $clog2(NUM_SEEDS) : 1;

    // Mixer constants.
    localparam logic [63:0] MIX_ADD  = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL2 = 64'h94d049bb133111eb;
    localparam logic [63:0] ALL_ONES = 64'hffffffffffffffff;

    // Partial product phases of one 64-bit multiply.
    localparam logic [1:0] PH_LO_LO = 2'd0;
    localparam logic [1:0] PH_HI_LO = 2'd1;
    localparam logic [1:0] PH_LO_HI = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE,
        ST_MUL,
        ST_MID,
        ST_FOLD,
        ST_EMIT
    } t_state;

    // Fixed seed for each slot.
    function automatic logic [63:0] seed_const(input logic [3:0] idx);
        logic [63:0] k;
        unique case (idx)
            4'd0:    k = 64'h243f6a8885a308d3;
            4'd1:    k = 64'h13198a2e03707344;
            4'd2:    k = 64'ha4093822299f31d0;
            4'd3:    k = 64'h082efa98ec4e6c89;
            4'd4:    k = 64'h452821e638d01377;
            4'd5:    k = 64'hbe5466cf34e90c6c;
            4'd6:    k = 64'hc0ac29b7c97c50dd;
            4'd7:    k = 64'h3f84d5b5b5470917;
            4'd8:    k = 64'h9216d5d98979fb1b;
            4'd9:    k = 64'hd1310ba698dfb5ac;
            4'd10:   k = 64'h2ffd72dbd01adfb7;
            4'd11:   k = 64'hb8e1afed6a267e96;
            4'd12:   k = 64'hba7c9045f12c7f99;
            4'd13:   k = 64'h24a19947b3916cf7;
            4'd14:   k = 64'h0801f2e2858efc16;
            default: k = 64'h636920d871574e69;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mh_if.sv =====
// Handshake channel interfaces for shingle requests and signature words.
`default_nettype none

interface mh_shingle_if;
    logic        valid;
    logic        ready;
    logic [63:0] shingle_hash;
    logic        hash_present;
    logic        end_of_text;

    modport source (output valid, output shingle_hash, output hash_present,
                    output end_of_text, input ready);
    modport sink   (input valid, input shingle_hash, input hash_present,
                    input end_of_text, output ready);
endinterface

interface mh_sig_if;
    logic        valid;
    logic        ready;
    logic [3:0]  sig_index;
    logic [63:0] sig_value;
    logic        sig_last;

    modport source (output valid, output sig_index, output sig_value,
                    output sig_last, input ready);
    modport sink   (input valid, input sig_index, input sig_value,
                    input sig_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/minhash_signature_engine.sv =====
// MinHash signature engine: one shared splitmix64 mixer folds shingles into per-seed minima.
//
// Usage: requests arrive on i_shingle (valid/ready). A request with hash_present
// set is mixed against every seed and folded into that seed's running minimum.
// A request with end_of_text set causes one signature word per seed on o_sig,
// in slot order, with sig_last on the final slot; an all-ones minimum reads as 0.
// A request with neither flag set is taken and dropped.
// A request with a hash occupies the block while every seed is processed in
// turn. Each seed goes through a pre-mix that xors the seed, two multiplies on
// the single shared 32x32 multiplier with a middle xor-shift between them, and
// a final step that finishes the mix and compares. i_shingle.ready is low for
// that whole time. Emitting then gives at most one word per cycle; each word
// waits while o_sig.ready is low, and the block takes no request until the
// last word is taken. Emitted slots return to all ones.
// Reset (i_rst_n low, synchronous) sets every minimum to all ones and returns
// the sequencer to idle; no clearing pass is needed.
`default_nettype none

module minhash_signature_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mh_shingle_if.sink      i_shingle,
    mh_sig_if.source        o_sig
);
    import mh_pkg::*;

    t_state              r_state, n_state;
    logic [SEED_W-1:0]   r_seed, n_seed;
    logic [1:0]          r_ph, n_ph;
    logic                r_pass, n_pass;
    logic                r_last, n_last;
    logic [63:0]         r_hash, n_hash;
    logic [63:0]         r_x, n_x;
    logic [63:0]         r_acc, n_acc;
    logic [63:0]         r_min [NUM_SEEDS];

    logic                w_in_acc;
    logic                w_out_acc;
    logic                w_seed_end;
    logic [63:0]         w_pre;
    logic [63:0]         w_mix;
    logic [63:0]         w_min_rd;
    logic [63:0]         w_k;
    logic [31:0]         w_mul_a;
    logic [31:0]         w_mul_b;
    logic [63:0]         w_prod;
    logic                w_upd;
    logic                w_clr;

    assign w_in_acc   = i_shingle.valid && i_shingle.ready;
    assign w_out_acc  = o_sig.valid && o_sig.ready;
    assign w_seed_end = (r_seed == SEED_W'(NUM_SEEDS - 1));
    assign w_min_rd   = r_min[r_seed];

    // Pre-mix: seed xor, golden-ratio add, first xor-shift.
    always_comb begin
        logic [63:0] v;
        v     = (r_hash ^ seed_const(4'(r_seed))) + MIX_ADD;
        w_pre = v ^ (v >> 30);
    end

    // Final xor-shift of the mixed value.
    assign w_mix = r_acc ^ (r_acc >> 31);

    // Shared 32x32 multiplier; operand halves chosen by phase.
    assign w_k = r_pass ? MIX_MUL2 : MIX_MUL1;
    always_comb begin
        case (r_ph)
            PH_HI_LO: begin
                w_mul_a = r_x[63:32];
                w_mul_b = w_k[31:0];
            end
            PH_LO_HI: begin
                w_mul_a = r_x[31:0];
                w_mul_b = w_k[63:32];
            end
            default: begin
                w_mul_a = r_x[31:0];
                w_mul_b = w_k[31:0];
            end
        endcase
    end
    assign w_prod = w_mul_a * w_mul_b;

    // Output channel is driven straight from the minimum store.
    assign i_shingle.ready = (r_state == ST_IDLE);
    assign o_sig.valid     = (r_state == ST_EMIT);
    assign o_sig.sig_index = 4'(r_seed);
    assign o_sig.sig_value = (w_min_rd == ALL_ONES) ? 64'd0 : w_min_rd;
    assign o_sig.sig_last  = w_seed_end;

    // Sequencer: next state and datapath controls.
    always_comb begin
        n_state = r_state;
        n_seed  = r_seed;
        n_ph    = r_ph;
        n_pass  = r_pass;
        n_last  = r_last;
        n_hash  = r_hash;
        n_x     = r_x;
        n_acc   = r_acc;
        w_upd   = 1'b0;
        w_clr   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_hash = i_shingle.shingle_hash;
                    n_last = i_shingle.end_of_text;
                    n_seed = '0;
                    if (i_shingle.hash_present) begin
                        n_state = ST_PRE;
                    end else if (i_shingle.end_of_text) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_PRE: begin
                n_x     = w_pre;
                n_pass  = 1'b0;
                n_ph    = PH_LO_LO;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                if (r_ph == PH_LO_LO) begin
                    n_acc = w_prod;
                end else begin
                    n_acc = {r_acc[63:32] + w_prod[31:0], r_acc[31:0]};
                end
                if (r_ph == PH_LO_HI) begin
                    n_ph    = PH_LO_LO;
                    n_state = r_pass ? ST_FOLD : ST_MID;
                end else begin
                    n_ph = r_ph + 2'd1;
                end
            end
            ST_MID: begin
                n_x     = r_acc ^ (r_acc >> 27);
                n_pass  = 1'b1;
                n_state = ST_MUL;
            end
            ST_FOLD: begin
                w_upd = (w_mix < w_min_rd);
                if (w_seed_end) begin
                    n_seed  = '0;
                    n_state = r_last ? ST_EMIT : ST_IDLE;
                end else begin
                    n_seed  = r_seed + SEED_W'(1);
                    n_state = ST_PRE;
                end
            end
            ST_EMIT: begin
                if (w_out_acc) begin
                    w_clr = 1'b1;
                    if (w_seed_end) begin
                        n_seed  = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_seed = r_seed + SEED_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_seed  <= '0;
            r_ph    <= PH_LO_LO;
            r_pass  <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_seed  <= n_seed;
            r_ph    <= n_ph;
            r_pass  <= n_pass;
            r_last  <= n_last;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_hash <= n_hash;
        r_x    <= n_x;
        r_acc  <= n_acc;
    end

    // Running minima, one per seed slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SEEDS; s++) begin
                r_min[s] <= ALL_ONES;
            end
        end else if (w_clr) begin
            r_min[r_seed] <= ALL_ONES;
        end else if (w_upd) begin
            r_min[r_seed] <= w_mix;
        end
    end

    // A request is never taken while a signature word is on offer.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |-> !o_sig.valid)
        else $error("request accepted while signature pending");

    // A request with a hash keeps the block busy on the next cycle.
    a_busy_after_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_shingle.hash_present) |=> !i_shingle.ready)
        else $error("ready while mixing");

    // Signature words follow in slot order.
    a_sig_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && !o_sig.sig_last) |=>
            (o_sig.valid && (o_sig.sig_index == 4'($past(o_sig.sig_index) + 4'd1))))
        else $error("signature slot skipped");

    // The block is idle again right after the last word is taken.
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_sig.sig_last) |=> i_shingle.ready)
        else $error("not idle after final signature word");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the MinHash signature engine with a handshake driver and monitor.
`timescale 1ns / 100ps

module tb;

    import mh_pkg::*;

    localparam logic [63:0] ONES64 = 64'hffffffffffffffff;
    localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MUL_A  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MUL_B  = 64'h94d049bb133111eb;
    localparam int          SLOTS  = 16;

    // One shingle request as it is queued for the driver.
    typedef struct packed {
        logic [63:0] hash;
        logic        present;
        logic        last;
    } t_shingle_req;

    // One predicted signature word.
    typedef struct packed {
        logic [3:0]  index;
        logic [63:0] value;
        logic        last;
    } t_sig_word;

    logic i_clk;
    logic i_rst_n;

    mh_shingle_if shingle_ch ();
    mh_sig_if     sig_ch ();

    minhash_signature_engine DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_shingle (shingle_ch),
        .o_sig     (sig_ch)
    );

    // Seed per slot, kept locally so the predictor stands on its own.
    logic [63:0] seed_tab [SLOTS] = '{
        64'h243f6a8885a308d3, 64'h13198a2e03707344,
        64'ha4093822299f31d0, 64'h082efa98ec4e6c89,
        64'h452821e638d01377, 64'hbe5466cf34e90c6c,
        64'hc0ac29b7c97c50dd, 64'h3f84d5b5b5470917,
        64'h9216d5d98979fb1b, 64'hd1310ba698dfb5ac,
        64'h2ffd72dbd01adfb7, 64'hb8e1afed6a267e96,
        64'hba7c9045f12c7f99, 64'h24a19947b3916cf7,
        64'h0801f2e2858efc16, 64'h636920d871574e69
    };

    logic [63:0]  slot_minimum [SLOTS];
    t_shingle_req pending_reqs [$];
    t_sig_word    expected_words [$];

    int errors        = 0;
    int reqs_total    = 0;
    int reqs_accepted = 0;
    int texts_closed  = 0;
    int words_checked = 0;
    int hashed_reqs   = 0;

    // splitmix64 finalizer.
    function automatic logic [63:0] splitmix(input logic [63:0] v);
        logic [63:0] z;
        z = v + GOLDEN;
        z = (z ^ (z >> 30)) * MUL_A;
        z = (z ^ (z >> 27)) * MUL_B;
        return z ^ (z >> 31);
    endfunction

    // Undo v ^ (v >> s) by fixed-point iteration.
    function automatic logic [63:0] undo_shift_xor(input logic [63:0] y, input int s);
        logic [63:0] x;
        x = y;
        for (int k = 0; k < 64; k++) x = y ^ (x >> s);
        return x;
    endfunction

    // Inverse of an odd constant modulo 2^64 by Newton iteration.
    function automatic logic [63:0] odd_inverse(input logic [63:0] c);
        logic [63:0] x;
        x = c;
        for (int k = 0; k < 6; k++) x = x * (64'd2 - c * x);
        return x;
    endfunction

    // Preimage of the finalizer, used to hit a mixed value of all ones.
    function automatic logic [63:0] splitmix_preimage(input logic [63:0] y);
        logic [63:0] z;
        z = undo_shift_xor(y, 31) * odd_inverse(MUL_B);
        z = undo_shift_xor(z, 27) * odd_inverse(MUL_A);
        return undo_shift_xor(z, 30) - GOLDEN;
    endfunction

    // Fold one accepted request into the minima and queue the signature on end of text.
    function automatic void fold_request(input logic [63:0] hash, input logic present,
                                         input logic last);
        logic [63:0] mixed;
        t_sig_word   w;
        if (present) begin
            for (int s = 0; s < SLOTS; s++) begin
                mixed = splitmix(hash ^ seed_tab[s]);
                if (mixed < slot_minimum[s]) slot_minimum[s] = mixed;
            end
        end
        if (last) begin
            for (int s = 0; s < SLOTS; s++) begin
                w.index = 4'(s);
                w.value = (slot_minimum[s] == ONES64) ? 64'd0 : slot_minimum[s];
                w.last  = (s == SLOTS - 1);
                expected_words = {expected_words, w};
                slot_minimum[s] = ONES64;
            end
            texts_closed++;
        end
    endfunction

    task automatic push_req(input logic [63:0] hash, input logic present, input logic last);
        t_shingle_req r;
        r.hash    = hash;
        r.present = present;
        r.last    = last;
        pending_reqs = {pending_reqs, r};
        reqs_total++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Random hash content with some extremes and repeats mixed in.
    function automatic logic [63:0] pick_hash(input logic [63:0] prev);
        case ($urandom_range(0, 15))
            0:       return 64'd0;
            1:       return ONES64;
            2:       return prev;
            3:       return 64'($urandom_range(0, 255));
            default: return rand64();
        endcase
    endfunction

    // Clock generation.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Request driver: bursts of random length with random gaps between them.
    int           burst_left = 4;
    int           gap_left   = 0;
    t_shingle_req next_req;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shingle_ch.valid <= 1'b0;
        end else begin
            if (shingle_ch.valid && shingle_ch.ready) begin
                fold_request(shingle_ch.shingle_hash, shingle_ch.hash_present,
                             shingle_ch.end_of_text);
                reqs_accepted++;
            end
            if (!shingle_ch.valid || shingle_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    shingle_ch.valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    next_req = pending_reqs.pop_front();
                    shingle_ch.shingle_hash <= next_req.hash;
                    shingle_ch.hash_present <= next_req.present;
                    shingle_ch.end_of_text  <= next_req.last;
                    shingle_ch.valid        <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 12);
                        // Long gaps can reach past the busy time so idle phases see them too.
                        gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                               : $urandom_range(0, 6);
                    end
                end else begin
                    shingle_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Signature receiver: the stall pattern is picked anew at random from four modes.
    int stall_mode  = 0;
    int pattern_cyc = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sig_ch.ready <= 1'b0;
            pattern_cyc  = 0;
        end else begin
            if (pattern_cyc % 48 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0:       sig_ch.ready <= 1'b1;
                1:       sig_ch.ready <= 1'($urandom_range(0, 1));
                2:       sig_ch.ready <= (pattern_cyc % 5 == 0);
                default: sig_ch.ready <= (pattern_cyc % 48 >= 20);
            endcase
            pattern_cyc++;
        end
    end

    // Signature monitor: compares each accepted word with the oldest prediction.
    t_sig_word want;

    always @(posedge i_clk) begin
        if (i_rst_n && sig_ch.valid && sig_ch.ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected signature word index=%0d value=%h last=%b",
                         $time, sig_ch.sig_index, sig_ch.sig_value, sig_ch.sig_last);
                errors++;
            end else begin
                want = expected_words.pop_front();
                words_checked++;
                if (sig_ch.sig_index !== want.index) begin
                    $display("%0t: sig_index expected %0d, got %0d",
                             $time, want.index, sig_ch.sig_index);
                    errors++;
                end
                if (sig_ch.sig_value !== want.value) begin
                    $display("%0t: sig_value slot %0d expected %h, got %h",
                             $time, want.index, want.value, sig_ch.sig_value);
                    errors++;
                end
                if (sig_ch.sig_last !== want.last) begin
                    $display("%0t: sig_last slot %0d expected %b, got %b",
                             $time, want.index, want.last, sig_ch.sig_last);
                    errors++;
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        logic [63:0] hit_ones_3;
        logic [63:0] hit_ones_15;
        logic [63:0] prev;
        int          text_len;

        shingle_ch.valid        = 1'b0;
        shingle_ch.shingle_hash = 64'd0;
        shingle_ch.hash_present = 1'b0;
        shingle_ch.end_of_text  = 1'b0;
        sig_ch.ready            = 1'b0;
        i_rst_n                 = 1'b0;
        for (int s = 0; s < SLOTS; s++) slot_minimum[s] = ONES64;

        hit_ones_3  = splitmix_preimage(ONES64) ^ seed_tab[3];
        hit_ones_15 = splitmix_preimage(ONES64) ^ seed_tab[15];

        // Directed: empty texts back to back, ignored requests, field extremes.
        push_req(64'd0, 1'b0, 1'b1);
        push_req(ONES64, 1'b0, 1'b1);
        push_req(ONES64, 1'b0, 1'b0);
        push_req(64'd0, 1'b1, 1'b0);
        push_req(ONES64, 1'b1, 1'b0);
        push_req(64'h8000000000000000, 1'b1, 1'b0);
        push_req(64'd1, 1'b1, 1'b0);
        push_req(64'h5555555555555555, 1'b1, 1'b1);
        // A text closed by an end marker without a hash, with a stray request inside.
        push_req(64'haaaaaaaaaaaaaaaa, 1'b1, 1'b0);
        push_req(64'h0123456789abcdef, 1'b0, 1'b0);
        push_req(64'h0123456789abcdef, 1'b1, 1'b0);
        push_req(64'hfedcba9876543210, 1'b0, 1'b1);
        // Mixed value of all ones in one slot reads back as zero.
        push_req(hit_ones_3, 1'b1, 1'b0);
        push_req(64'd0, 1'b0, 1'b1);
        push_req(hit_ones_15, 1'b1, 1'b1);
        push_req(hit_ones_3, 1'b1, 1'b0);
        push_req(64'h00000000ffffffff, 1'b1, 1'b1);
        // Same hash twice, then an ignored request right before the end.
        push_req(64'hdeadbeefcafef00d, 1'b1, 1'b0);
        push_req(64'hdeadbeefcafef00d, 1'b1, 1'b0);
        push_req(rand64(), 1'b0, 1'b0);
        push_req(64'hffffffff00000000, 1'b0, 1'b1);

        // Random texts of varied length until the request count is reached.
        prev = rand64();
        while (reqs_total < 430) begin
            text_len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24)
                                                   : $urandom_range(0, 7);
            for (int k = 0; k < text_len; k++) begin
                if ($urandom_range(0, 11) == 0) push_req(rand64(), 1'b0, 1'b0);
                prev = pick_hash(prev);
                push_req(prev, 1'b1, 1'b0);
            end
            if ($urandom_range(0, 1) == 0) begin
                prev = pick_hash(prev);
                push_req(prev, 1'b1, 1'b1);
            end else begin
                push_req(rand64(), 1'b0, 1'b1);
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to go in and every word to come out.
        do @(negedge i_clk); while (reqs_accepted < reqs_total);
        do @(negedge i_clk); while (expected_words.size() > 0);
        repeat (200) @(negedge i_clk);

        $display("Run covered %0d requests and %0d texts; %0d signature words compared.",
                 reqs_accepted, texts_closed, words_checked);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches found.", errors);
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #8_000_000;
        $display("Timeout with %0d of %0d requests accepted, %0d words outstanding.",
                 reqs_accepted, reqs_total, expected_words.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule
